// ===== src/mop_pkg.sv =====
// Shared types, constants and arithmetic helpers of the orbit-trap pixel unit.
`default_nettype none

package mop_pkg;

  // Fixed-point format of the orbit and the point c.
  localparam int unsigned FRAC_BITS = 26;
  localparam int unsigned C_W       = 32;

  // Orbit components carry eight integer bits, enough for |z| below 128.
  localparam int unsigned ZW = FRAC_BITS + 8;
  localparam int unsigned MW = ZW - 1;
  // Truncated product of two components, with sign.
  localparam int unsigned PW = 2 * MW - FRAC_BITS + 1;
  localparam int unsigned SW = PW + 1;

  // Iteration counting.
  localparam int unsigned ITER_MAX = 64;
  localparam int unsigned IW       = 7;

  // Configuration port.
  localparam int unsigned GAIN_W    = 6;
  localparam int unsigned OFS_W     = 8;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Log2 unit.
  localparam int unsigned MANT_W     = 31;
  localparam int unsigned LOG_FRAC_W = 8;
  localparam int unsigned K_W        = $clog2(LOG_FRAC_W);
  localparam int unsigned POS_W      = $clog2(MW);
  localparam int unsigned LOG_W      = POS_W + LOG_FRAC_W;
  localparam int unsigned NEGL_W     = LOG_W + 2;
  localparam int unsigned PROD_W     = NEGL_W + GAIN_W + 1;
  localparam int unsigned PAL_W      = 8;

  // Escape radius squared and the smallest trap distance (about 1e-5).
  localparam logic signed [SW-1:0] BAIL = SW'(64'd64 << FRAC_BITS);
  localparam longint unsigned FloorRaw = (64'd1 << FRAC_BITS) / 64'd100000;
  localparam logic [MW-1:0] TRAP_FLOOR = MW'((FloorRaw == 0) ? 64'd1 : FloorRaw);
  localparam logic signed [NEGL_W-1:0] NEGL_BASE = NEGL_W'(FRAC_BITS * 256);

  // Register reset values.
  localparam logic [IW-1:0]     MAX_ITER_RST = 7'd40;
  localparam logic [GAIN_W-1:0] GAIN_RST     = 6'd26;
  localparam logic [OFS_W-1:0]  OFS_RST      = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER = 2'd0,
    REG_GAIN     = 2'd1,
    REG_OFFSET   = 2'd2
  } mop_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_NORM,
    ST_SQR,
    ST_SCALE,
    ST_FIN
  } mop_state_e;

  typedef struct packed {
    logic [IW-1:0]     max_iterations;
    logic [GAIN_W-1:0] filigree_gain;
    logic [OFS_W-1:0]  palette_offset;
  } mop_cfg_t;

  typedef struct packed {
    logic load_c;
    logic upd;
    logic norm;
    logic sqr;
    logic scale;
    logic load_out;
  } mop_cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic escape;
    logic last_iter;
    logic norm_done;
    logic sqr_last;
  } mop_stat_t;

  // Fixed-point product: magnitude truncated toward zero, then signed.
  function automatic logic signed [PW-1:0] fx_mul(logic signed [ZW-1:0] a,
                                                   logic signed [ZW-1:0] b);
    logic            neg;
    logic [MW-1:0]   ma;
    logic [MW-1:0]   mb;
    logic [2*MW-1:0] prod;
    logic [PW-1:0]   mag;
    neg  = a[ZW-1] ^ b[ZW-1];
    ma   = MW'(a[ZW-1] ? -a : a);
    mb   = MW'(b[ZW-1] ? -b : b);
    prod = ma * mb;
    mag  = {1'b0, prod[2*MW-1:FRAC_BITS]};
    return neg ? $signed(-mag) : $signed(mag);
  endfunction

endpackage

`default_nettype wire

// ===== src/mop_in_if.sv =====
// Input channel carrying one point c per item.
`default_nettype none

interface mop_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [mop_pkg::C_W-1:0]     c_real;
  logic signed [mop_pkg::C_W-1:0]     c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

`default_nettype wire

// ===== src/mop_out_if.sv =====
// Output channel carrying one pixel result per item.
`default_nettype none

interface mop_out_if;
  logic                          valid;
  logic                          ready;
  logic                          escaped;
  logic [mop_pkg::IW-1:0]        iteration_count;
  logic [mop_pkg::PAL_W-1:0]     palette_index;

  modport source (output valid, output escaped, output iteration_count,
                  output palette_index, input ready);
  modport sink   (input valid, input escaped, input iteration_count,
                  input palette_index, output ready);
endinterface

`default_nettype wire

// ===== src/mop_datapath.sv =====
// Datapath: orbit iteration, trap tracking, log2 unit, palette scaling, result register.
`default_nettype none

module mop_datapath (
  input  logic                          clk_i,
  input  mop_pkg::mop_cfg_t             cfg_i,
  input  logic signed [mop_pkg::C_W-1:0] c_real_i,
  input  logic signed [mop_pkg::C_W-1:0] c_imag_i,
  input  mop_pkg::mop_cmd_t             cmd_i,
  output mop_pkg::mop_stat_t            stat_o,
  output logic                          escaped_o,
  output logic [mop_pkg::IW-1:0]        iteration_count_o,
  output logic [mop_pkg::PAL_W-1:0]     palette_index_o
);
  import mop_pkg::*;

  // Orbit state and point.
  logic signed [ZW-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [PW-1:0] prr_q, pii_q, pri_q;
  logic [MW-1:0]        trap_q;
  logic [IW-1:0]        n_q;
  logic                 esc_q;

  // Log2 unit state.
  logic [MW-1:0]         norm_q;
  logic [POS_W-1:0]      sh_q;
  logic [MANT_W-1:0]     m_q;
  logic [LOG_FRAC_W-1:0] frac_q;
  logic [K_W-1:0]        k_q;
  logic signed [PROD_W-1:0] prod_q;

  // Result register.
  logic             out_esc_q;
  logic [IW-1:0]    out_cnt_q;
  logic [PAL_W-1:0] out_pal_q;

  // Combinational values.
  logic [IW-1:0]          limit;
  logic signed [SW-1:0]   mag_sum;
  logic signed [PW+1:0]   nzr_full, nzi_full;
  logic signed [ZW-1:0]   zr_d, zi_d;
  logic [MW-1:0]          mag_r, mag_i, tmin, trap_d, trap_clamp;
  logic [2*MANT_W-1:0]    sq_full;
  logic [MANT_W:0]        sq;
  logic [MANT_W-1:0]      m_d;
  logic [POS_W-1:0]       pos;
  logic signed [NEGL_W-1:0] negl;
  logic [PROD_W-1:0]      prod_mag, prod_shr;
  logic [PAL_W-1:0]       idx8, pal_d;

  // Effective iteration limit, saturated at the largest supported count.
  assign limit = (cfg_i.max_iterations > IW'(ITER_MAX)) ? IW'(ITER_MAX)
                                                        : cfg_i.max_iterations;

  // Escape test and orbit update from the registered products.
  assign mag_sum  = SW'(prr_q) + SW'(pii_q);
  assign nzr_full = (PW+2)'(prr_q) - (PW+2)'(pii_q) + (PW+2)'(cr_q);
  assign nzi_full = ((PW+2)'(pri_q) <<< 1) + (PW+2)'(ci_q);
  assign zr_d     = ZW'(nzr_full);
  assign zi_d     = ZW'(nzi_full);

  // Orbit trap: least of the smaller component magnitude.
  assign mag_r      = MW'(zr_d[ZW-1] ? -zr_d : zr_d);
  assign mag_i      = MW'(zi_d[ZW-1] ? -zi_d : zi_d);
  assign tmin       = (mag_r < mag_i) ? mag_r : mag_i;
  assign trap_d     = (tmin < trap_q) ? tmin : trap_q;
  assign trap_clamp = (trap_q < TRAP_FLOOR) ? TRAP_FLOOR : trap_q;

  // One squaring step of the mantissa yields one fraction bit of log2.
  assign sq_full = m_q * m_q;
  assign sq      = sq_full[2*MANT_W-1:MANT_W-1];
  assign m_d     = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];

  // Leading-one position of the trap and the scaled negative log.
  assign pos  = POS_W'(MW - 1) - sh_q;
  assign negl = NEGL_BASE - NEGL_W'({pos, frac_q});

  // Divide by 256 with truncation toward zero, then add the offset.
  assign prod_mag = PROD_W'(-prod_q);
  assign prod_shr = prod_q[PROD_W-1] ? (prod_mag >> LOG_FRAC_W)
                                     : (PROD_W'(prod_q) >> LOG_FRAC_W);
  assign idx8     = prod_q[PROD_W-1] ? (PAL_W'(0) - prod_shr[PAL_W-1:0])
                                     : prod_shr[PAL_W-1:0];
  assign pal_d    = idx8 + cfg_i.palette_offset;

  // Status toward the controller.
  assign stat_o.limit_zero = (limit == '0);
  assign stat_o.escape     = (mag_sum > BAIL);
  assign stat_o.last_iter  = (IW'(n_q + 1'b1) == limit);
  assign stat_o.norm_done  = norm_q[MW-1];
  assign stat_o.sqr_last   = (k_q == K_W'(LOG_FRAC_W - 1));

  // The three component products are registered every cycle.
  always_ff @(posedge clk_i) begin
    prr_q <= fx_mul(zr_q, zr_q);
    pii_q <= fx_mul(zi_q, zi_q);
    pri_q <= fx_mul(zr_q, zi_q);
  end

  // Orbit registers: load a new point, then update or stop on escape.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_c) begin
      cr_q   <= ZW'(c_real_i);
      ci_q   <= ZW'(c_imag_i);
      zr_q   <= '0;
      zi_q   <= '0;
      trap_q <= '1;
      n_q    <= '0;
      esc_q  <= 1'b0;
    end else if (cmd_i.upd) begin
      if (stat_o.escape) begin
        esc_q  <= 1'b1;
      end else begin
        zr_q   <= zr_d;
        zi_q   <= zi_d;
        trap_q <= trap_d;
        n_q    <= IW'(n_q + 1'b1);
      end
    end
  end

  // Log2 unit: take the clamped trap on escape, normalize by eight or one bit
  // a cycle, then square eight times.
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && stat_o.escape) begin
      norm_q <= trap_clamp;
      sh_q   <= '0;
    end else if (cmd_i.norm) begin
      if (norm_q[MW-1]) begin
        m_q    <= norm_q[MW-1 -: MANT_W];
        frac_q <= '0;
        k_q    <= '0;
      end else if (norm_q[MW-1 -: 8] == '0) begin
        norm_q <= norm_q << 8;
        sh_q   <= sh_q + POS_W'(8);
      end else begin
        norm_q <= norm_q << 1;
        sh_q   <= sh_q + POS_W'(1);
      end
    end else if (cmd_i.sqr) begin
      m_q    <= m_d;
      frac_q <= {frac_q[LOG_FRAC_W-2:0], sq[MANT_W]};
      k_q    <= K_W'(k_q + 1'b1);
    end
    if (cmd_i.scale) begin
      prod_q <= $signed(PROD_W'(negl) * PROD_W'({1'b0, cfg_i.filigree_gain}));
    end
  end

  // Result register, loaded once the item is finished.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_esc_q <= esc_q;
      out_cnt_q <= n_q;
      out_pal_q <= esc_q ? pal_d : '0;
    end
  end

  assign escaped_o         = out_esc_q;
  assign iteration_count_o = out_cnt_q;
  assign palette_index_o   = out_pal_q;

endmodule

`default_nettype wire

// ===== src/mop_ctrl.sv =====
// Controller: sequences iterations, the log2 unit and the result handoff.
`default_nettype none

module mop_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  mop_pkg::mop_stat_t stat_i,
  output mop_pkg::mop_cmd_t  cmd_o
);
  import mop_pkg::*;

  mop_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The result register can take a new item when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.limit_zero ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (stat_i.escape) begin
          state_d = ST_NORM;
        end else if (stat_i.last_iter) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_NORM: begin
        if (stat_i.norm_done) begin
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        if (stat_i.sqr_last) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath and handshake outputs.
  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    cmd_o          = '0;
    cmd_o.load_c   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.upd      = (state_q == ST_UPD);
    cmd_o.norm     = (state_q == ST_NORM);
    cmd_o.sqr      = (state_q == ST_SQR);
    cmd_o.scale    = (state_q == ST_SCALE);
    cmd_o.load_out = (state_q == ST_FIN) && out_free;
  end

  // The result stays valid until taken; a new one is loaded only once it is taken or gone.
  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/mandelbrot_orbit_trap_pixel_unit.sv =====
// Top level of the orbit-trap pixel unit: configuration registers, controller, datapath.
`default_nettype none

// Iterates z = z*z + c from zero for one point c (signed Q6.26) until |z|^2
// exceeds 64 or the configured limit (saturated at 64) is reached, tracking
// the orbit trap. One item is worked on at a time. An item is accepted, then
// each orbit iteration passes the three registered component multipliers and
// then the escape test and update. An escaped point, after the escape test
// that stops the orbit, adds the log2 unit: normalization, repeated squaring
// and a final scaling. Then the result moves into the output register; this
// waits while an untaken result still holds the register. The next item is
// accepted while the previous result still waits in the output register.
// Configuration writes are expected only while the unit is idle.

module mandelbrot_orbit_trap_pixel_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mop_in_if.sink                         in_ch,
  mop_out_if.source                      out_ch,
  input  logic                           cfg_we_i,
  input  logic [mop_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mop_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import mop_pkg::*;

  mop_cfg_t  cfg_q;
  mop_cmd_t  cmd;
  mop_stat_t stat;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_iterations <= MAX_ITER_RST;
      cfg_q.filigree_gain  <= GAIN_RST;
      cfg_q.palette_offset <= OFS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAX_ITER: cfg_q.max_iterations <= cfg_wdata_i[IW-1:0];
        REG_GAIN:     cfg_q.filigree_gain  <= cfg_wdata_i[GAIN_W-1:0];
        REG_OFFSET:   cfg_q.palette_offset <= cfg_wdata_i[OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mop_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mop_datapath u_datapath (
    .clk_i             (clk_i),
    .cfg_i             (cfg_q),
    .c_real_i          (in_ch.c_real),
    .c_imag_i          (in_ch.c_imag),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .escaped_o         (out_ch.escaped),
    .iteration_count_o (out_ch.iteration_count),
    .palette_index_o   (out_ch.palette_index)
  );

  // An accepted item keeps the unit busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted again right after an item was taken");

  // A point that stayed inside reports a zero palette index.
  a_interior_palette: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.escaped |-> out_ch.palette_index == '0)
    else $error("interior point with nonzero palette index");

  // An escape needs at least one completed iteration and stays within the limit.
  a_escape_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.escaped |->
      out_ch.iteration_count != '0 && out_ch.iteration_count < IW'(ITER_MAX))
    else $error("escaped point with impossible iteration count");

endmodule

`default_nettype wire
